### src/zled_pkg.sv
`default_nettype none

package zled_pkg;

  // phase codes double as the byte kind reported for that phase
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_EXTRA  = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_IGNORE = 3'd4;
  localparam logic [2:0] PH_REJECT = 3'd5;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
  localparam logic [2:0] ERR_ENCRYPTED  = 3'd2;
  localparam logic [2:0] ERR_DESCRIPTOR = 3'd3;
  localparam logic [2:0] ERR_METHOD     = 3'd4;

  localparam logic [1:0] METH_STORED  = 2'd0;
  localparam logic [1:0] METH_DEFLATE = 2'd1;
  localparam logic [1:0] METH_OTHER   = 2'd2;

  localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
  localparam logic [31:0] SIG_END     = 32'h06054b50;

  localparam logic [15:0] METHOD_STORED  = 16'd0;
  localparam logic [15:0] METHOD_DEFLATE = 16'd8;

  localparam logic [4:0] HDR_LAST = 5'd29;

  // header byte offsets that are captured
  localparam logic [4:0] OFS_SIG0   = 5'd0;
  localparam logic [4:0] OFS_SIG1   = 5'd1;
  localparam logic [4:0] OFS_SIG2   = 5'd2;
  localparam logic [4:0] OFS_SIG3   = 5'd3;
  localparam logic [4:0] OFS_FLAG0  = 5'd6;
  localparam logic [4:0] OFS_FLAG1  = 5'd7;
  localparam logic [4:0] OFS_METH0  = 5'd8;
  localparam logic [4:0] OFS_METH1  = 5'd9;
  localparam logic [4:0] OFS_SIZE0  = 5'd18;
  localparam logic [4:0] OFS_SIZE1  = 5'd19;
  localparam logic [4:0] OFS_SIZE2  = 5'd20;
  localparam logic [4:0] OFS_SIZE3  = 5'd21;
  localparam logic [4:0] OFS_NAME0  = 5'd26;
  localparam logic [4:0] OFS_NAME1  = 5'd27;
  localparam logic [4:0] OFS_EXTRA0 = 5'd28;
  localparam logic [4:0] OFS_EXTRA1 = 5'd29;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  header_index;
    logic [31:0] signature_word;
    logic [15:0] flag_bits;
    logic [15:0] method_word;
    logic [31:0] body_size;
    logic [15:0] name_size;
    logic [15:0] extra_size;
    logic [31:0] bytes_left;
    logic [2:0]  sticky_error;
  } state_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_out;
    logic [1:0]  method;
    logic        entry_done;
    logic [2:0]  error_code;
    logic [31:0] entry_size;
  } result_t;

  function automatic logic [1:0] method_class(input logic [15:0] w);
    logic [1:0] c;
    if (w == METHOD_STORED) c = METH_STORED;
    else if (w == METHOD_DEFLATE) c = METH_DEFLATE;
    else c = METH_OTHER;
    return c;
  endfunction

endpackage

`default_nettype wire

### src/zled_step.sv
`default_nettype none

module zled_step
  import zled_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] data_byte,
  output state_t     st_next,
  output result_t    res
);

  logic do_adv;

  always_comb begin
    st_next        = st;
    do_adv         = 1'b0;
    res.byte_kind  = st.phase;
    res.data_out   = data_byte;
    res.method     = METH_STORED;
    res.entry_done = 1'b0;
    res.error_code = ERR_NONE;
    res.entry_size = 32'd0;

    unique case (st.phase)
      PH_HEADER: begin
        case (st.header_index)
          OFS_SIG0:   st_next.signature_word = {24'd0, data_byte};
          OFS_SIG1:   st_next.signature_word[15:8] = data_byte;
          OFS_SIG2:   st_next.signature_word[23:16] = data_byte;
          OFS_SIG3:   st_next.signature_word[31:24] = data_byte;
          OFS_FLAG0:  st_next.flag_bits = {8'd0, data_byte};
          OFS_FLAG1:  st_next.flag_bits[15:8] = data_byte;
          OFS_METH0:  st_next.method_word = {8'd0, data_byte};
          OFS_METH1:  st_next.method_word[15:8] = data_byte;
          OFS_SIZE0:  st_next.body_size = {24'd0, data_byte};
          OFS_SIZE1:  st_next.body_size[15:8] = data_byte;
          OFS_SIZE2:  st_next.body_size[23:16] = data_byte;
          OFS_SIZE3:  st_next.body_size[31:24] = data_byte;
          OFS_NAME0:  st_next.name_size = {8'd0, data_byte};
          OFS_NAME1:  st_next.name_size[15:8] = data_byte;
          OFS_EXTRA0: st_next.extra_size = {8'd0, data_byte};
          OFS_EXTRA1: st_next.extra_size[15:8] = data_byte;
          default: ;
        endcase
        st_next.header_index = st.header_index + 5'd1;
        if (st.header_index == HDR_LAST) begin
          // of the captured fields, only extra_size changes on the last header byte
          st_next.header_index = 5'd0;
          if (st.signature_word == SIG_CENTRAL || st.signature_word == SIG_END) begin
            st_next.phase = PH_IGNORE;
          end else if (st.signature_word != SIG_LOCAL) begin
            st_next.phase        = PH_REJECT;
            st_next.sticky_error = ERR_SIGNATURE;
            res.error_code       = ERR_SIGNATURE;
          end else if (st.flag_bits[0]) begin
            st_next.phase        = PH_REJECT;
            st_next.sticky_error = ERR_ENCRYPTED;
            res.error_code       = ERR_ENCRYPTED;
          end else if (st.flag_bits[3]) begin
            st_next.phase        = PH_REJECT;
            st_next.sticky_error = ERR_DESCRIPTOR;
            res.error_code       = ERR_DESCRIPTOR;
          end else begin
            res.method         = method_class(st.method_word);
            res.entry_size     = st.body_size;
            st_next.phase      = PH_NAME;
            st_next.bytes_left = {16'd0, st.name_size};
            do_adv             = 1'b1;
          end
        end
      end
      PH_NAME, PH_EXTRA, PH_BODY: begin
        res.method     = method_class(st.method_word);
        res.entry_size = st.body_size;
        if (st.bytes_left != 32'd0) st_next.bytes_left = st.bytes_left - 32'd1;
        do_adv = 1'b1;
      end
      PH_IGNORE: ;
      default: begin
        res.byte_kind  = PH_REJECT;
        res.error_code = st.sticky_error;
      end
    endcase

    // skip finished and empty sections, at most name -> extra -> body -> done
    if (do_adv && st_next.bytes_left == 32'd0) begin
      if (st_next.phase == PH_NAME) begin
        st_next.phase      = PH_EXTRA;
        st_next.bytes_left = {16'd0, st_next.extra_size};
      end
      if (st_next.phase == PH_EXTRA && st_next.bytes_left == 32'd0) begin
        st_next.phase      = PH_BODY;
        st_next.bytes_left = st_next.body_size;
      end
      if (st_next.phase == PH_BODY && st_next.bytes_left == 32'd0) begin
        res.entry_done = 1'b1;
        if (method_class(st_next.method_word) == METH_OTHER) begin
          st_next.phase        = PH_REJECT;
          st_next.sticky_error = ERR_METHOD;
          res.error_code       = ERR_METHOD;
        end else begin
          st_next.phase        = PH_HEADER;
          st_next.header_index = 5'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/zip_local_entry_deframer_core.sv
`default_nettype none

// ZIP local entry deframer. Takes one archive byte per transfer and returns one
// tagged result per byte in the cycle after its transfer, one byte per cycle
// while the output side does not stall: the parse state and the result register
// are both updated in the same cycle. The input is stalled only while a result
// sits in the output register and the output side stalls. Errors are sticky until
// reset; after a central directory or end record all bytes are marked ignored.

module zip_local_entry_deframer_core
  import zled_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       byte_kind,
  output logic [7:0]       data_out,
  output logic [1:0]       method,
  output logic             entry_done,
  output logic [2:0]       error_code,
  output logic [31:0]      entry_size
);

  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;
  logic    accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  zled_step u_step (
    .st        (st),
    .data_byte (data_byte),
    .st_next   (st_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_HEADER, default: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign byte_kind  = res.byte_kind;
  assign data_out   = res.data_out;
  assign method     = res.method;
  assign entry_done = res.entry_done;
  assign error_code = res.error_code;
  assign entry_size = res.entry_size;

  // empty trailing sections can close an entry on a header, name or extra byte
  a_done_on_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_done |-> byte_kind <= PH_BODY)
    else $error("entry_done outside an entry byte");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> byte_kind != PH_IGNORE)
    else $error("error code on ignored byte");

  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_REJECT |-> st.sticky_error != ERR_NONE)
    else $error("reject phase without stored error");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result");

endmodule

`default_nettype wire
